/* sv/maf_pkg.sv */
// ----------------------------------------------------------------------------
// maf_pkg: shared types and constants for the moving average filter
// Default sizes, the window register format and the sequencer states.
// ----------------------------------------------------------------------------
package maf_pkg;

  localparam int MAX_WINDOW_DEF   = 64;
  localparam int SAMPLE_WIDTH_DEF = 16;

  // window_length register: 7 bits, resets to a window of 64
  localparam int          WIN_REG_W   = 7;
  localparam logic [6:0]  WIN_REG_RST = 7'd64;

  typedef enum logic [2:0] {
    S_IDLE,   // waiting for a sample word
    S_READ,   // ring entry read back, sum updated
    S_ABS,    // split sum into sign and magnitude
    S_DIV,    // one quotient bit per cycle
    S_FIX,    // restore sign of the quotient
    S_OUT     // hand result to the output register
  } state_t;

endpackage

/* sv/maf_sample_if.sv */
// ----------------------------------------------------------------------------
// maf_sample_if: sample stream channel
// Valid/ready channel carrying one signed sample word.
// ----------------------------------------------------------------------------
interface maf_sample_if #(
  parameter int W = maf_pkg::SAMPLE_WIDTH_DEF
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

/* sv/maf_average_if.sv */
// ----------------------------------------------------------------------------
// maf_average_if: average stream channel
// Valid/ready channel carrying one signed average word.
// ----------------------------------------------------------------------------
interface maf_average_if #(
  parameter int W = maf_pkg::SAMPLE_WIDTH_DEF
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] average;

  modport source (output valid, output average, input ready);
  modport sink   (input valid, input average, output ready);
endinterface

/* sv/moving_average_filter.sv */
// ----------------------------------------------------------------------------
// moving_average_filter: boxcar moving average with bit-serial divider
// Averages the last window_length signed samples, truncating toward zero.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------
//  in_if   | in  | valid & ready      | sample  (SAMPLE_WIDTH, signed)
//  out_if  | out | valid & ready      | average (SAMPLE_WIDTH, signed)
//  cfg     | in  | cfg_we (no ready)  | cfg_wdata = window_length (7 bits)
//
//  A primed sample passes S_READ, S_ABS, S_DIV and S_FIX before S_OUT loads
//    the output register, and the next word is taken back in S_IDLE; the
//    restoring divider in S_DIV makes one quotient bit per cycle over the
//    SUM_W-bit sum magnitude.
//  A priming word (first after reset or a window write) goes from S_IDLE
//    straight to S_OUT, which loads it into the output register.
//  One word in flight; in_if.ready is high only while the sequencer idles.
//  Output register decouples the sink: the next word is accepted while a
//    result still waits, and the sequencer holds in S_OUT if it is still full.
//  Reset (rst_n low, synchronous) clears control only; the ring needs no
//    clearing pass since unread entries are covered by the priming value.
//
module moving_average_filter #(
  parameter int MAX_WINDOW   = maf_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_WIDTH = maf_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  maf_sample_if.sink                      in_if,
  maf_average_if.source                   out_if,
  input  logic                            cfg_we,
  input  logic [maf_pkg::WIN_REG_W-1:0]   cfg_wdata
);

  localparam int SW    = SAMPLE_WIDTH;
  localparam int LEN_W = $clog2(MAX_WINDOW + 1);              // holds 1..MAX_WINDOW
  localparam int POS_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int SUM_W = SW + $clog2(MAX_WINDOW);              // holds len * sample
  localparam int CNT_W = $clog2(SUM_W + 1);
  localparam int PRD_W = SW + LEN_W + 1;

  maf_pkg::state_t state_r, state_nxt;

  logic [maf_pkg::WIN_REG_W-1:0] win_r;
  logic                          primed_r;
  logic                          wrapped_r;   // ring lap done since priming
  logic                          use_mem_r;   // read data is a real entry
  logic [POS_W-1:0]              pos_r;

  logic signed [SW-1:0]          sample_r;
  logic signed [SW-1:0]          prime_val_r;
  logic signed [SUM_W-1:0]       sum_r;
  logic                          neg_r;
  logic [SUM_W-1:0]              dvd_r;       // dividend in, quotient out
  logic [LEN_W-1:0]              rem_r;
  logic [CNT_W-1:0]              cnt_r;
  logic signed [SW-1:0]          result_r;

  logic                          out_valid_r;
  logic signed [SW-1:0]          out_avg_r;

  logic signed [SW-1:0]          ring_mem [MAX_WINDOW];
  logic signed [SW-1:0]          rd_r;

  // --- effective window: 0 acts as 1, above MAX_WINDOW clamps ---
  logic [31:0]       win32;
  logic [LEN_W-1:0]  len_eff;
  always_comb begin
    win32 = 32'(win_r);
    priority if (win32 == 32'd0) begin
      len_eff = LEN_W'(1);
    end else if (win32 > 32'(MAX_WINDOW)) begin
      len_eff = LEN_W'(MAX_WINDOW);
    end else begin
      len_eff = win32[LEN_W-1:0];
    end
  end

  // --- control decode ---
  logic in_acc, out_load, out_free;
  assign out_free = !out_valid_r || out_if.ready;
  assign in_acc   = in_if.valid && in_if.ready;

  always_comb begin
    in_if.ready = 1'b0;
    out_load    = 1'b0;
    unique case (state_r)
      maf_pkg::S_IDLE: in_if.ready = 1'b1;
      maf_pkg::S_OUT:  out_load    = out_free;
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      maf_pkg::S_IDLE: begin
        if (in_acc) state_nxt = primed_r ? maf_pkg::S_READ : maf_pkg::S_OUT;
      end
      maf_pkg::S_READ: state_nxt = maf_pkg::S_ABS;
      maf_pkg::S_ABS:  state_nxt = maf_pkg::S_DIV;
      maf_pkg::S_DIV: begin
        if (cnt_r == CNT_W'(1)) state_nxt = maf_pkg::S_FIX;
      end
      maf_pkg::S_FIX:  state_nxt = maf_pkg::S_OUT;
      maf_pkg::S_OUT: begin
        if (out_free) state_nxt = maf_pkg::S_IDLE;
      end
      default: state_nxt = maf_pkg::S_IDLE;
    endcase
  end

  // --- next ring position, wraps at the window ---
  logic [LEN_W-1:0] pos_inc;
  logic [POS_W-1:0] pos_nxt;
  always_comb begin
    pos_inc = LEN_W'(pos_r) + LEN_W'(1);
    pos_nxt = (pos_inc == len_eff) ? '0 : pos_inc[POS_W-1:0];
  end

  // priming sum: window times sample
  logic signed [PRD_W-1:0] prime_prod;
  assign prime_prod = PRD_W'(in_if.sample) * $signed({1'b0, len_eff});

  // oldest entry leaving the window; before the first lap it is the prime value
  logic signed [SW-1:0] old_val;
  assign old_val = use_mem_r ? rd_r : prime_val_r;

  // restoring divider step
  logic [LEN_W:0]   rem_sh;
  logic             q_bit;
  logic [LEN_W:0]   rem_sub;
  logic [SW-1:0]    q_mag;
  assign rem_sh  = {rem_r, dvd_r[SUM_W-1]};
  assign q_bit   = (rem_sh >= {1'b0, len_eff});
  assign rem_sub = rem_sh - {1'b0, len_eff};
  assign q_mag   = dvd_r[SW-1:0];

  // --- ring memory: read-before-write at the same address ---
  always_ff @(posedge clk) begin
    if (state_r == maf_pkg::S_IDLE && in_acc && primed_r) begin
      ring_mem[pos_nxt] <= in_if.sample;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == maf_pkg::S_IDLE && in_acc && primed_r) begin
      rd_r <= ring_mem[pos_nxt];
    end
  end

  // --- control registers ---
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= maf_pkg::S_IDLE;
      win_r       <= maf_pkg::WIN_REG_RST;
      primed_r    <= 1'b0;
      wrapped_r   <= 1'b0;
      pos_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        win_r    <= cfg_wdata;
        primed_r <= 1'b0;
      end
      if (state_r == maf_pkg::S_IDLE && in_acc) begin
        if (!primed_r) begin
          primed_r  <= 1'b1;
          pos_r     <= '0;
          wrapped_r <= 1'b0;
        end else begin
          pos_r     <= pos_nxt;
          wrapped_r <= wrapped_r || (pos_nxt == '0);
        end
      end
      unique case (state_r)
        maf_pkg::S_ABS: cnt_r <= CNT_W'(SUM_W);
        maf_pkg::S_DIV: cnt_r <= cnt_r - CNT_W'(1);
        default: ;
      endcase
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // --- datapath registers ---
  always_ff @(posedge clk) begin
    unique case (state_r)
      maf_pkg::S_IDLE: begin
        if (in_acc) begin
          sample_r  <= in_if.sample;
          use_mem_r <= wrapped_r;
          if (!primed_r) begin
            prime_val_r <= in_if.sample;
            sum_r       <= SUM_W'(prime_prod);
            result_r    <= in_if.sample;
          end
        end
      end
      maf_pkg::S_READ: begin
        sum_r <= sum_r - SUM_W'(old_val) + SUM_W'(sample_r);
      end
      maf_pkg::S_ABS: begin
        neg_r <= sum_r[SUM_W-1];
        dvd_r <= sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
        rem_r <= '0;
      end
      maf_pkg::S_DIV: begin
        dvd_r <= {dvd_r[SUM_W-2:0], q_bit};
        rem_r <= q_bit ? rem_sub[LEN_W-1:0] : rem_sh[LEN_W-1:0];
      end
      maf_pkg::S_FIX: begin
        result_r <= neg_r ? SW'(-q_mag) : SW'(q_mag);
      end
      maf_pkg::S_OUT: begin
        if (out_load) out_avg_r <= result_r;
      end
      default: ;
    endcase
  end

  assign out_if.valid   = out_valid_r;
  assign out_if.average = out_avg_r;

`ifndef SYNTHESIS
  // remainder stays below the divisor through the divide
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == maf_pkg::S_DIV) |-> (rem_r < len_eff))
    else $error("divider remainder out of range");

  // bit counter never runs out while dividing
  a_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == maf_pkg::S_DIV) |-> (cnt_r != '0))
    else $error("divider counter underflow");

  // ring position stays inside the window once primed
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    primed_r |-> (LEN_W'(pos_r) < len_eff))
    else $error("ring position outside window");

  // a priming word goes straight out unchanged
  a_prime_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == maf_pkg::S_IDLE && in_acc && !primed_r) |=>
      (state_r == maf_pkg::S_OUT && result_r == $past(in_if.sample)))
    else $error("priming word not passed through");

  // an accepted word always leaves idle
  a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != maf_pkg::S_IDLE))
    else $error("accepted word dropped");
`endif

endmodule
